[hdl/tmpc_pkg.sv]
// Shared types and constants for the thruster mixer position controller.
// Used by tmpc_mul, tmpc_core and the top level; depends on nothing else.
package tmpc_pkg;

	// Axis and thruster counts.
	localparam int NUM_AXES = 3;
	localparam int NUM_THR  = 6;

	// Field widths.
	localparam int VEL_W  = 16;
	localparam int POS_W  = 32;
	localparam int GAIN_W = 16;
	localparam int CHAN_W = 3;
	localparam int TGT_W  = 14;
	localparam int AX_W   = 2;

	// Shared multiplier operand and product widths.
	localparam int MA_W = 34;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;

	// Force term (Q.12) and speed sum widths.
	localparam int TERM_W = 37;
	localparam int SP_W   = 40;

	// Arithmetic constants.
	localparam int TENTH_Q16    = 6554;
	localparam int TGT_SCALE    = 1000;
	localparam int TGT_BASE_Q12 = 6000 * 4096;
	localparam logic [TGT_W-1:0] TGT_MAX = 14'h3FFF;
	localparam logic [7:0] CMD_OPCODE = 8'h84;

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_VEL  = 2'd0,
		KIND_TICK = 2'd1,
		KIND_POS  = 2'd2,
		KIND_MODE = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_GAIN_X = 2'd0,
		REG_GAIN_Y = 2'd1,
		REG_GAIN_Z = 2'd2
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_MUL,
		ST_TICK_ADD,
		ST_FRC_MUL,
		ST_FRC_STO,
		ST_TGT_MUL,
		ST_TGT_OUT
	} state_t;

	// One thruster result handed from the core to the output register.
	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] chan;
		logic [TGT_W-1:0]  target;
		logic              last;
	} res_t;

endpackage

[hdl/tmpc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on tmpc_pkg for the operand widths.
module tmpc_mul
	import tmpc_pkg::*;
(
	input  logic                   clk,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic signed [MP_W-1:0] p_q
);

	// One product per cycle; the product is registered and appears in the cycle after its operands.
	always_ff @(posedge clk) begin
		p_q <= MP_W'(a) * MP_W'(b);
	end

endmodule

[hdl/tmpc_core.sv]
// Sequencer, controller state and datapath around the shared multiplier.
// Depends on tmpc_pkg and tmpc_mul.
module tmpc_core
	import tmpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic signed [VEL_W-1:0]  lin_x,
	input  logic signed [VEL_W-1:0]  lin_y,
	input  logic signed [VEL_W-1:0]  lin_z,
	input  logic signed [VEL_W-1:0]  ang_x,
	input  logic signed [VEL_W-1:0]  ang_y,
	input  logic signed [VEL_W-1:0]  ang_z,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic                     loop_on,
	input  logic signed [GAIN_W-1:0] gain_x,
	input  logic signed [GAIN_W-1:0] gain_y,
	input  logic signed [GAIN_W-1:0] gain_z,
	output res_t                     res,
	input  logic                     res_take
);

	state_t state_q, state_d;

	logic                    loop_closed_q;
	logic                    capture_pending_q;
	logic [AX_W-1:0]         idx_q;
	logic [CHAN_W-1:0]       k_q;
	logic [POS_W-1:0]        ref_pos_q  [NUM_AXES];
	logic [VEL_W-1:0]        ref_rate_q [NUM_AXES];
	logic [POS_W-1:0]        pos_q      [NUM_AXES];
	logic signed [TERM_W-1:0] term_q    [NUM_THR];

	logic                    accept;
	logic                    idx_last;
	logic                    k_last;
	logic signed [GAIN_W-1:0] gain_sel;
	logic [POS_W:0]          err;
	logic signed [SP_W-1:0]  sp_full;
	logic signed [MB_W-1:0]  sp_sat;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [MP_W-1:0]  mul_p;
	logic [29:0]             tsum;
	logic [17:0]             tq;
	logic [TGT_W-1:0]        tgt;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign idx_last = (idx_q == AX_W'(NUM_AXES - 1));
	assign k_last   = (k_q == CHAN_W'(NUM_THR - 1));

	// Gain of the axis in work.
	always_comb begin
		unique case (idx_q)
			2'd0:    gain_sel = gain_x;
			2'd1:    gain_sel = gain_y;
			default: gain_sel = gain_z;
		endcase
	end

	// Position error in 33 bits, exact.
	assign err = {ref_pos_q[idx_q][POS_W-1], ref_pos_q[idx_q]}
		- {pos_q[idx_q][POS_W-1], pos_q[idx_q]};

	// Mixing of the six speed terms for thruster k.
	always_comb begin
		unique case (k_q)
			3'd0:    sp_full = SP_W'(term_q[2]) - SP_W'(term_q[3]) - SP_W'(term_q[4]);
			3'd1:    sp_full = -SP_W'(term_q[2]) - SP_W'(term_q[3]) + SP_W'(term_q[4]);
			3'd2:    sp_full = SP_W'(term_q[1]) + SP_W'(term_q[5]);
			3'd3:    sp_full = -(SP_W'(term_q[0]) <<< 1);
			3'd4:    sp_full = -SP_W'(term_q[1]) + SP_W'(term_q[5]);
			3'd5:    sp_full = SP_W'(term_q[2]) + SP_W'(term_q[3]);
			default: sp_full = '0;
		endcase
	end

	// Clamp the speed to 18 bits; anything outside already saturates the target.
	always_comb begin
		if (sp_full[SP_W-1:MB_W-1] == '0 || sp_full[SP_W-1:MB_W-1] == '1) begin
			sp_sat = sp_full[MB_W-1:0];
		end else if (sp_full[SP_W-1]) begin
			sp_sat = {1'b1, {(MB_W-1){1'b0}}};
		end else begin
			sp_sat = {1'b0, {(MB_W-1){1'b1}}};
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = MA_W'(TGT_SCALE);
		mul_b = sp_sat;
		unique case (state_q)
			ST_TICK_MUL: begin
				mul_a = MA_W'($signed(ref_rate_q[idx_q]));
				mul_b = MB_W'(TENTH_Q16);
			end
			ST_FRC_MUL: begin
				mul_a = MA_W'($signed(err));
				mul_b = MB_W'(gain_sel);
			end
			default: begin
			end
		endcase
	end

	tmpc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Pulse target: 6000 plus the scaled speed, floored, then saturated.
	assign tsum = {mul_p[28], mul_p[28:0]} + 30'(TGT_BASE_Q12);
	assign tq   = tsum[29:12];

	always_comb begin
		if (tq[17]) begin
			tgt = '0;
		end else if (tq[16:TGT_W] != '0) begin
			tgt = TGT_MAX;
		end else begin
			tgt = tq[TGT_W-1:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		res.valid  = 1'b0;
		res.chan   = k_q;
		res.target = tgt;
		res.last   = k_last;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (kind_t'(kind))
						KIND_VEL:  if (!loop_closed_q) state_d = ST_TGT_MUL;
						KIND_TICK: if (loop_closed_q) state_d = ST_TICK_MUL;
						KIND_POS:  if (loop_closed_q) state_d = ST_FRC_MUL;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK_MUL: state_d = ST_TICK_ADD;
			ST_TICK_ADD: state_d = idx_last ? ST_IDLE : ST_TICK_MUL;
			ST_FRC_MUL:  state_d = ST_FRC_STO;
			ST_FRC_STO:  state_d = idx_last ? ST_TGT_MUL : ST_FRC_MUL;
			ST_TGT_MUL:  state_d = ST_TGT_OUT;
			ST_TGT_OUT: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = k_last ? ST_IDLE : ST_TGT_MUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller state: loop mode, references, rates and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_closed_q     <= 1'b0;
			capture_pending_q <= 1'b0;
			idx_q             <= '0;
			k_q               <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ref_pos_q[i]  <= '0;
				ref_rate_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				idx_q <= '0;
				k_q   <= '0;
				unique case (kind_t'(kind))
					KIND_VEL: begin
						if (loop_closed_q) begin
							ref_rate_q[0] <= lin_x;
							ref_rate_q[1] <= lin_y;
							ref_rate_q[2] <= lin_z;
						end
					end
					KIND_POS: begin
						if (capture_pending_q) begin
							ref_pos_q[0]      <= pos_x;
							ref_pos_q[1]      <= pos_y;
							ref_pos_q[2]      <= pos_z;
							capture_pending_q <= 1'b0;
						end
					end
					KIND_MODE: begin
						loop_closed_q <= loop_on;
						if (loop_on) begin
							capture_pending_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			// Reference advance by a tenth of the rate, wrapping at 32 bits.
			if (state_q == ST_TICK_ADD) begin
				ref_pos_q[idx_q] <= ref_pos_q[idx_q] + mul_p[43:12];
				idx_q            <= idx_q + 1'b1;
			end
			if (state_q == ST_FRC_STO) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_TGT_OUT && res_take) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Payload: measured position and the six speed terms.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			if (kind_t'(kind) == KIND_VEL) begin
				// The command's y and z swap places in the mix.
				term_q[0] <= TERM_W'(lin_x);
				term_q[1] <= TERM_W'(lin_z);
				term_q[2] <= TERM_W'(lin_y);
				term_q[3] <= TERM_W'(ang_x);
				term_q[4] <= TERM_W'(ang_y);
				term_q[5] <= TERM_W'(ang_z);
			end else begin
				term_q[3] <= '0;
				term_q[4] <= '0;
				term_q[5] <= '0;
			end
		end
		// Proportional force, floored to Q.12.
		if (state_q == ST_FRC_STO) begin
			term_q[CHAN_W'(idx_q)] <= mul_p[48:12];
		end
	end

endmodule

[hdl/thruster_mixer_position_controller.sv]
// Thruster mixer position controller: gain registers, core and output register.
// Open-loop velocity item: after the accept cycle, each thruster in turn takes a
// multiply state and an output state on the one shared multiplier. Closed-loop
// position item: first a multiply and a store per axis for forces. Closed-loop
// tick: a multiply and an add per axis. Other items end at accept.
// Asynchronous reset clears references, rates and loop mode; gains reset to 1.0.
module thruster_mixer_position_controller
	import tmpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic signed [VEL_W-1:0]  lin_x,
	input  logic signed [VEL_W-1:0]  lin_y,
	input  logic signed [VEL_W-1:0]  lin_z,
	input  logic signed [VEL_W-1:0]  ang_x,
	input  logic signed [VEL_W-1:0]  ang_y,
	input  logic signed [VEL_W-1:0]  ang_z,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic                     loop_on,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CHAN_W-1:0]        channel,
	output logic [TGT_W-1:0]         target,
	output logic [7:0]               cmd_byte,
	output logic [6:0]               target_low7,
	output logic [6:0]               target_high7,
	output logic                     last
);

	logic signed [GAIN_W-1:0] gain_x_q, gain_y_q, gain_z_q;
	res_t                     res;
	logic                     res_take;
	logic                     out_valid_q;
	logic [CHAN_W-1:0]        channel_q;
	logic [TGT_W-1:0]         target_q;
	logic                     last_q;

	// Gain registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q <= 16'sd256;
			gain_y_q <= 16'sd256;
			gain_z_q <= 16'sd256;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_X: gain_x_q <= cfg_data;
				REG_GAIN_Y: gain_y_q <= cfg_data;
				REG_GAIN_Z: gain_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tmpc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.lin_x    (lin_x),
		.lin_y    (lin_y),
		.lin_z    (lin_z),
		.ang_x    (ang_x),
		.ang_y    (ang_y),
		.ang_z    (ang_z),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.loop_on  (loop_on),
		.gain_x   (gain_x_q),
		.gain_y   (gain_y_q),
		.gain_z   (gain_z_q),
		.res      (res),
		.res_take (res_take)
	);

	// The output register takes a result when empty or when its transfer completes.
	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			channel_q <= res.chan;
			target_q  <= res.target;
			last_q    <= res.last;
		end
	end

	// Command packing.
	assign out_valid    = out_valid_q;
	assign channel      = channel_q;
	assign target       = target_q;
	assign cmd_byte     = CMD_OPCODE;
	assign target_low7  = target_q[6:0];
	assign target_high7 = target_q[13:7];
	assign last         = last_q;

endmodule

[test/testbench.sv]
// Self-checking testbench for the thruster mixer position controller.
// Depends on tmpc_pkg and thruster_mixer_position_controller; reads no files.
`timescale 1ns / 100ps

module testbench;
	import tmpc_pkg::*;

	// One input item, field by field, as the block sees it.
	typedef struct packed {
		kind_t                    kind;
		logic signed [VEL_W-1:0]  lin_x;
		logic signed [VEL_W-1:0]  lin_y;
		logic signed [VEL_W-1:0]  lin_z;
		logic signed [VEL_W-1:0]  ang_x;
		logic signed [VEL_W-1:0]  ang_y;
		logic signed [VEL_W-1:0]  ang_z;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic                     loop_on;
	} item_t;

	// One row of the directed table; typed rows carry their six targets.
	typedef struct packed {
		item_t                  item;
		logic                   typed;
		logic [0:5][TGT_W-1:0]  want;
	} row_t;

	// One expected thruster command.
	typedef struct packed {
		logic [CHAN_W-1:0]  chan;
		logic [TGT_W-1:0]   target;
		logic               last;
	} thrust_cmd_t;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam logic signed [VEL_W-1:0] V0   = 16'sh0000;
	localparam logic signed [VEL_W-1:0] VMAX = 16'sh7FFF;
	localparam logic signed [VEL_W-1:0] VMIN = 16'sh8000;
	localparam logic signed [VEL_W-1:0] VONE = 16'shFFFF;
	localparam logic signed [POS_W-1:0] P0   = 32'sh00000000;
	localparam logic signed [POS_W-1:0] PMAX = 32'sh7FFFFFFF;
	localparam logic signed [POS_W-1:0] PMIN = 32'sh80000000;
	localparam logic signed [POS_W-1:0] PONE = 32'shFFFFFFFF;
	localparam logic [TGT_W-1:0] MID = 14'd6000;
	localparam int RANDOM_PER_PHASE = 82;
	localparam int QUIET_CYCLES     = 40;
	localparam int LONG_HOLD        = 400;
	localparam int WATCHDOG_LIMIT   = 5000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [1:0]               cfg_index = '0;
	logic [GAIN_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               kind = '0;
	logic signed [VEL_W-1:0]  lin_x = '0;
	logic signed [VEL_W-1:0]  lin_y = '0;
	logic signed [VEL_W-1:0]  lin_z = '0;
	logic signed [VEL_W-1:0]  ang_x = '0;
	logic signed [VEL_W-1:0]  ang_y = '0;
	logic signed [VEL_W-1:0]  ang_z = '0;
	logic signed [POS_W-1:0]  pos_x = '0;
	logic signed [POS_W-1:0]  pos_y = '0;
	logic signed [POS_W-1:0]  pos_z = '0;
	logic                     loop_on = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [CHAN_W-1:0]        channel;
	logic [TGT_W-1:0]         target;
	logic [7:0]               cmd_byte;
	logic [6:0]               target_low7;
	logic [6:0]               target_high7;
	logic                     last;

	// Controller state as the checker tracks it.
	logic signed [GAIN_W-1:0] gain_q8 [NUM_AXES];
	logic signed [POS_W-1:0]  setpoint [NUM_AXES];
	logic signed [VEL_W-1:0]  setpoint_rate [NUM_AXES];
	logic                     loop_closed;
	logic                     capture_armed;

	thrust_cmd_t pending_cmds [$];
	thrust_cmd_t seen_cmd;
	int fail_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	// Directed items: extremes, every kind, capture and loop-mode corner cases.
	row_t directed_rows [24] = '{
		// Open loop right after reset: zero command and saturating extremes.
		'{'{KIND_VEL, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b1,
			'{MID, MID, MID, MID, MID, MID}},
		'{'{KIND_VEL, VMAX, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b1,
			'{MID, MID, MID, 14'd0, MID, MID}},
		'{'{KIND_VEL, VMIN, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b1,
			'{MID, MID, MID, TGT_MAX, MID, MID}},
		'{'{KIND_VEL, V0, VMAX, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b1,
			'{14'd13999, 14'd0, MID, MID, MID, 14'd13999}},
		'{'{KIND_VEL, V0, V0, VMIN, VMAX, VMAX, VMAX, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_VEL, VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, P0, P0, P0, 1'b0}, 1'b0, '0},
		// Tick and position in open loop with nothing armed.
		'{'{KIND_TICK, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, PMAX, PMAX, PMAX, 1'b1},
			1'b0, '0},
		'{'{KIND_POS, V0, V0, V0, V0, V0, V0, 32'sh00012345, PMIN, PMAX, 1'b0},
			1'b0, '0},
		// Close then open: the capture stays armed and fires in open loop.
		'{'{KIND_MODE, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b1}, 1'b0, '0},
		'{'{KIND_MODE, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_POS, V0, V0, V0, V0, V0, V0, 32'sh00010000, 32'shFFFF0000,
			32'sh7FFFF000, 1'b0}, 1'b0, '0},
		'{'{KIND_VEL, 16'sh1000, 16'shF000, 16'sh0800, 16'sh0400, 16'shFC00, 16'sh0200,
			P0, P0, P0, 1'b0}, 1'b0, '0},
		// Closed loop: rates, capture with zero error, ticks that wrap a setpoint.
		'{'{KIND_MODE, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b1}, 1'b0, '0},
		'{'{KIND_VEL, VMAX, VMIN, VMAX, VONE, VONE, VONE, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_POS, V0, V0, V0, V0, V0, V0, 32'sh7FFFF000, P0, PMIN, 1'b0}, 1'b1,
			'{MID, MID, MID, MID, MID, MID}},
		'{'{KIND_TICK, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_TICK, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_POS, V0, V0, V0, V0, V0, V0, PMIN, PMAX, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_VEL, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_TICK, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_POS, V0, V0, V0, V0, V0, V0, PMAX, PMIN, PMAX, 1'b0}, 1'b0, '0},
		// Back to open loop with every unused bit set.
		'{'{KIND_MODE, VONE, VONE, VONE, VONE, VONE, VONE, PONE, PONE, PONE, 1'b0},
			1'b0, '0},
		'{'{KIND_POS, V0, V0, V0, V0, V0, V0, 32'sh00001000, PONE, P0, 1'b0}, 1'b0, '0},
		'{'{KIND_VEL, V0, V0, V0, V0, V0, V0, P0, P0, P0, 1'b0}, 1'b1,
			'{MID, MID, MID, MID, MID, MID}}
	};

	thruster_mixer_position_controller i_dut (.*);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mix six thruster speeds (Q.12) and turn them into saturated pulse targets.
	task automatic mix_thrusters(input longint xs, ys, zs, ax, ay, az,
			ref thrust_cmd_t cmds [$]);
		longint speed [NUM_THR];
		longint pulse;
		thrust_cmd_t c;
		speed = '{zs - ax - ay, -zs - ax + ay, ys + az, -2 * xs, -ys + az, zs + ax};
		for (int k = 0; k < NUM_THR; k++) begin
			pulse = (longint'(TGT_BASE_Q12) + longint'(TGT_SCALE) * speed[k]) >>> 12;
			c.chan = CHAN_W'(k);
			if (pulse < 0)
				c.target = '0;
			else if (pulse > longint'(TGT_MAX))
				c.target = TGT_MAX;
			else
				c.target = pulse[TGT_W-1:0];
			c.last = (k == NUM_THR - 1);
			cmds.push_back(c);
		end
	endtask

	// Advance the controller state by one item and collect the commands it causes.
	task automatic predict_controller(input item_t s, ref thrust_cmd_t cmds [$]);
		logic signed [POS_W-1:0] meas [NUM_AXES];
		logic signed [VEL_W-1:0] cmd_lin [NUM_AXES];
		longint frc [NUM_AXES];
		longint step;
		meas = '{s.pos_x, s.pos_y, s.pos_z};
		cmd_lin = '{s.lin_x, s.lin_y, s.lin_z};
		case (s.kind)
			KIND_VEL: begin
				// Open loop mixes the command with y and z swapped.
				if (!loop_closed)
					mix_thrusters(s.lin_x, s.lin_z, s.lin_y, s.ang_x, s.ang_y, s.ang_z, cmds);
				else
					setpoint_rate = cmd_lin;
			end
			KIND_TICK: begin
				if (loop_closed)
					for (int a = 0; a < NUM_AXES; a++) begin
						step = (longint'(setpoint_rate[a]) * TENTH_Q16) >>> 12;
						setpoint[a] = setpoint[a] + step[POS_W-1:0];
					end
			end
			KIND_POS: begin
				if (capture_armed) begin
					setpoint = meas;
					capture_armed = 1'b0;
				end
				for (int a = 0; a < NUM_AXES; a++)
					frc[a] = (longint'(gain_q8[a]) *
						(longint'(setpoint[a]) - longint'(meas[a]))) >>> 12;
				if (loop_closed)
					mix_thrusters(frc[0], frc[1], frc[2], 0, 0, 0, cmds);
			end
			default: begin
				loop_closed = s.loop_on;
				if (s.loop_on)
					capture_armed = 1'b1;
			end
		endcase
	endtask

	// Velocity field: full range, an extreme, or a small command.
	function automatic logic signed [VEL_W-1:0] rand_vel();
		logic [31:0] r;
		int small_v;
		r = $urandom;
		small_v = int'($urandom_range(8191)) - 4096;
		case ($urandom_range(3))
			0: return r[VEL_W-1:0];
			1: return $urandom_range(1) ? VMAX : VMIN;
			default: return small_v[VEL_W-1:0];
		endcase
	endfunction

	// Position field: full range, an extreme, or close to the current setpoint.
	function automatic logic signed [POS_W-1:0] rand_pos(input logic signed [POS_W-1:0] near);
		logic [31:0] r;
		int offset;
		r = $urandom;
		offset = int'($urandom_range(262143)) - 131072;
		case ($urandom_range(3))
			0: return r;
			1: return $urandom_range(1) ? PMAX : PMIN;
			default: return near + offset;
		endcase
	endfunction

	// Random item, weighted toward closed-loop sequences of rates, ticks and positions.
	function automatic item_t random_item();
		item_t s;
		int pick;
		s.lin_x = rand_vel();
		s.lin_y = rand_vel();
		s.lin_z = rand_vel();
		s.ang_x = rand_vel();
		s.ang_y = rand_vel();
		s.ang_z = rand_vel();
		s.pos_x = rand_pos(setpoint[0]);
		s.pos_y = rand_pos(setpoint[1]);
		s.pos_z = rand_pos(setpoint[2]);
		s.loop_on = ($urandom_range(99) < 75);
		pick = $urandom_range(99);
		if (pick < 30)
			s.kind = KIND_VEL;
		else if (pick < 50)
			s.kind = KIND_TICK;
		else if (pick < 90)
			s.kind = KIND_POS;
		else
			s.kind = KIND_MODE;
		return s;
	endfunction

	// Offer one item until it transfers, then queue the commands it should cause.
	task automatic run_item(input row_t r);
		thrust_cmd_t cmds [$];
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= r.item.kind;
		lin_x    <= r.item.lin_x;
		lin_y    <= r.item.lin_y;
		lin_z    <= r.item.lin_z;
		ang_x    <= r.item.ang_x;
		ang_y    <= r.item.ang_y;
		ang_z    <= r.item.ang_z;
		pos_x    <= r.item.pos_x;
		pos_y    <= r.item.pos_y;
		pos_z    <= r.item.pos_z;
		loop_on  <= r.item.loop_on;
		do @(posedge clk); while (in_stall);
		predict_controller(r.item, cmds);
		if (r.typed)
			foreach (cmds[k])
				cmds[k].target = r.want[k];
		foreach (cmds[k])
			pending_cmds.push_back(cmds[k]);
	endtask

	// Let the block drain and settle, then load all three gains and poke the unused index.
	task automatic program_gains(input logic signed [GAIN_W-1:0] gx, gy, gz);
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAIN_X;
		cfg_data  <= gx;
		@(posedge clk);
		cfg_index <= REG_GAIN_Y;
		cfg_data  <= gy;
		@(posedge clk);
		cfg_index <= REG_GAIN_Z;
		cfg_data  <= gz;
		@(posedge clk);
		cfg_index <= REG_NONE;
		cfg_data  <= GAIN_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		gain_q8 = '{gx, gy, gz};
	endtask

	// Receiver: random stalls, plus one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_given != hold_asked) begin
			out_stall  <= 1'b1;
			hold_left  <= LONG_HOLD;
			hold_given <= hold_asked;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Compare each transferred command with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cmds.size() == 0) begin
				$error("unexpected command: channel %0d target %0d", channel, target);
				fail_count++;
			end else begin
				seen_cmd = pending_cmds.pop_front();
				if (channel !== seen_cmd.chan) begin
					$error("channel: expected %0d, got %0d", seen_cmd.chan, channel);
					fail_count++;
				end
				if (target !== seen_cmd.target) begin
					$error("target: expected %0d, got %0d", seen_cmd.target, target);
					fail_count++;
				end
				if (cmd_byte !== CMD_OPCODE) begin
					$error("cmd_byte: expected %0h, got %0h", CMD_OPCODE, cmd_byte);
					fail_count++;
				end
				if (target_low7 !== seen_cmd.target[6:0]) begin
					$error("target_low7: expected %0d, got %0d",
						seen_cmd.target[6:0], target_low7);
					fail_count++;
				end
				if (target_high7 !== seen_cmd.target[13:7]) begin
					$error("target_high7: expected %0d, got %0d",
						seen_cmd.target[13:7], target_high7);
					fail_count++;
				end
				if (last !== seen_cmd.last) begin
					$error("last: expected %0d, got %0d", seen_cmd.last, last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("thruster_mixer_position_controller verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Main sequence: reset, directed table, then three random phases.
	initial begin
		gain_q8 = '{16'sd256, 16'sd256, 16'sd256};
		setpoint = '{P0, P0, P0};
		setpoint_rate = '{V0, V0, V0};
		loop_closed = 1'b0;
		capture_armed = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with sender and receiver both idling.
		tx_idle_pct = 8;
		rx_idle_pct = 81;
		foreach (directed_rows[i])
			run_item(directed_rows[i]);

		// Gain extremes; sender rarely idle, receiver mostly stalled.
		program_gains(16'sh7FFF, 16'sh8000, 16'sh0000);
		repeat (RANDOM_PER_PHASE) run_item('{random_item(), 1'b0, '0});

		// Random gains; sender mostly idle, receiver rarely stalled.
		program_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
		tx_idle_pct = 81;
		rx_idle_pct = 8;
		repeat (RANDOM_PER_PHASE) run_item('{random_item(), 1'b0, '0});

		// Moderate gains at full rate, opening with a long receiver hold-off.
		program_gains(16'sd1, -16'sd256, 16'sd512);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_asked <= hold_asked + 1;
		repeat (RANDOM_PER_PHASE) run_item('{random_item(), 1'b0, '0});

		// Drain and report.
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("thruster_mixer_position_controller verification clean");
		else
			$display("thruster_mixer_position_controller verification failed");
		$finish;
	end

endmodule
